### hw/rtl/sgs_pkg.sv
// shared types, constants and gait set-point table for the servo gait sequencer
package sgs_pkg;

    localparam int SERVO_COUNT = 8;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MODE = 2'd1;
    localparam logic [1:0] KIND_SET  = 2'd2;
    localparam logic [1:0] KIND_RAMP = 2'd3;

    localparam logic [2:0] MODE_REST = 3'd0;
    localparam logic [2:0] MODE_MAX  = 3'd4;

    localparam logic [1:0] REG_LONG_PHASE = 2'd0;
    localparam logic [1:0] REG_WATCHDOG   = 2'd1;
    localparam logic [1:0] REG_INVERT     = 2'd2;

    localparam logic [9:0]  LONG_PHASE_RST = 10'd220;
    localparam logic [11:0] WATCHDOG_RST   = 12'd2000;
    localparam logic [7:0]  INVERT_RST     = 8'd89;

    localparam logic [7:0]  STAND_ANGLE  = 8'd45;
    localparam logic [7:0]  ANGLE_MAX    = 8'd180;
    localparam logic [7:0]  INVERT_PIVOT = 8'd90;
    localparam logic [7:0]  RAMP_STEP    = 8'd3;
    localparam logic [3:0]  RAMP_PERIOD  = 4'd15;
    localparam logic [11:0] AGE_MAX      = 12'd4095;
    localparam logic [11:0] PULSE_MIN    = 12'd732;
    localparam logic [11:0] PULSE_SPAN   = 12'd2197;

    typedef struct packed {
        logic [9:0]  long_phase_ms;
        logic [11:0] watchdog_ms;
        logic [7:0]  invert_mask;
    } t_cfg;

    typedef struct packed {
        logic [2:0] ch;
        logic [7:0] ang;
    } t_gait_entry;

    typedef struct packed {
        logic [2:0] ch;
        logic [7:0] ang;
        logic [2:0] mode_now;
        logic       last;
    } t_wr_req;

    // indexed by {mode - 1, phase, write}
    localparam t_gait_entry GAIT_TABLE [64] = '{
        '{3'd5, 8'd25}, '{3'd7, 8'd65}, '{3'd0, 8'd70}, '{3'd3, 8'd70},
        '{3'd5, 8'd45}, '{3'd7, 8'd45}, '{3'd0, 8'd45}, '{3'd3, 8'd45},
        '{3'd4, 8'd65}, '{3'd6, 8'd25}, '{3'd1, 8'd20}, '{3'd2, 8'd20},
        '{3'd4, 8'd45}, '{3'd6, 8'd45}, '{3'd1, 8'd45}, '{3'd2, 8'd45},
        '{3'd4, 8'd25}, '{3'd6, 8'd65}, '{3'd1, 8'd70}, '{3'd2, 8'd70},
        '{3'd4, 8'd45}, '{3'd6, 8'd45}, '{3'd1, 8'd45}, '{3'd2, 8'd45},
        '{3'd5, 8'd65}, '{3'd7, 8'd25}, '{3'd0, 8'd20}, '{3'd3, 8'd20},
        '{3'd5, 8'd45}, '{3'd7, 8'd45}, '{3'd0, 8'd45}, '{3'd3, 8'd45},
        '{3'd5, 8'd30}, '{3'd4, 8'd60}, '{3'd0, 8'd70}, '{3'd1, 8'd70},
        '{3'd5, 8'd45}, '{3'd4, 8'd45}, '{3'd0, 8'd45}, '{3'd1, 8'd45},
        '{3'd6, 8'd60}, '{3'd7, 8'd30}, '{3'd2, 8'd20}, '{3'd3, 8'd20},
        '{3'd6, 8'd45}, '{3'd7, 8'd45}, '{3'd2, 8'd45}, '{3'd3, 8'd45},
        '{3'd6, 8'd30}, '{3'd7, 8'd60}, '{3'd2, 8'd70}, '{3'd3, 8'd70},
        '{3'd6, 8'd45}, '{3'd7, 8'd45}, '{3'd2, 8'd45}, '{3'd3, 8'd45},
        '{3'd5, 8'd60}, '{3'd4, 8'd30}, '{3'd0, 8'd20}, '{3'd1, 8'd20},
        '{3'd5, 8'd45}, '{3'd4, 8'd45}, '{3'd0, 8'd45}, '{3'd1, 8'd45}
    };

endpackage

### hw/rtl/sgs_if.sv
// command and servo-write channel interfaces
interface sgs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] mode;
    logic [2:0] channel;
    logic [7:0] angle;

    modport source (output valid, output kind, output mode, output channel, output angle,
                    input ready);
    modport sink   (input valid, input kind, input mode, input channel, input angle,
                    output ready);
endinterface

interface sgs_wr_if;
    logic        valid;
    logic        ready;
    logic [2:0]  servo_channel;
    logic [7:0]  servo_angle;
    logic [11:0] pulse_us;
    logic [2:0]  mode_now;
    logic        last;

    modport source (output valid, output servo_channel, output servo_angle,
                    output pulse_us, output mode_now, output last, input ready);
    modport sink   (input valid, input servo_channel, input servo_angle,
                    input pulse_us, input mode_now, input last, output ready);
endinterface

### hw/rtl/sgs_cfg.sv
// apb configuration registers
module sgs_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output sgs_pkg::t_cfg      o_cfg
);

    sgs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_phase_ms <= sgs_pkg::LONG_PHASE_RST;
            r_cfg.watchdog_ms   <= sgs_pkg::WATCHDOG_RST;
            r_cfg.invert_mask   <= sgs_pkg::INVERT_RST;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (i_paddr[3:2])
                sgs_pkg::REG_LONG_PHASE: r_cfg.long_phase_ms <= i_pwdata[9:0];
                sgs_pkg::REG_WATCHDOG:   r_cfg.watchdog_ms   <= i_pwdata[11:0];
                sgs_pkg::REG_INVERT:     r_cfg.invert_mask   <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            sgs_pkg::REG_LONG_PHASE: o_prdata = {22'd0, r_cfg.long_phase_ms};
            sgs_pkg::REG_WATCHDOG:   o_prdata = {20'd0, r_cfg.watchdog_ms};
            sgs_pkg::REG_INVERT:     o_prdata = {24'd0, r_cfg.invert_mask};
            default:                 o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/sgs_writer.sv
// shared servo write unit: inversion, clamp, pulse width and output register
module sgs_writer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgs_pkg::t_cfg     i_cfg,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  sgs_pkg::t_wr_req  i_req,
    sgs_wr_if.source          o_wr
);

    // floor(y / 45) = (y * RECIP_45) >> 23 for y below 2**17
    localparam logic [17:0] RECIP_45 = 18'd186414;

    logic        r_s1_valid;
    logic [2:0]  r_s1_ch;
    logic [7:0]  r_s1_f;
    logic [18:0] r_s1_x;
    logic [2:0]  r_s1_mode;
    logic        r_s1_last;

    logic        r_out_valid;
    logic [2:0]  r_out_ch;
    logic [7:0]  r_out_f;
    logic [11:0] r_out_pulse;
    logic [2:0]  r_out_mode;
    logic        r_out_last;

    logic        w_out_free;
    logic        w_s1_move;
    logic        w_take;
    logic [7:0]  w_f;
    logic [18:0] w_x;
    logic [34:0] w_prod;
    logic [11:0] w_pulse;

    assign w_out_free  = !r_out_valid || o_wr.ready;
    assign w_s1_move   = r_s1_valid && w_out_free;
    assign o_req_ready = !r_s1_valid || w_s1_move;
    assign w_take      = i_req_valid && o_req_ready;

    always_comb begin
        if (i_cfg.invert_mask[i_req.ch]) begin
            w_f = (i_req.ang >= sgs_pkg::INVERT_PIVOT) ? 8'd0 : sgs_pkg::INVERT_PIVOT - i_req.ang;
        end else begin
            w_f = i_req.ang;
        end
        if (w_f > sgs_pkg::ANGLE_MAX) begin
            w_f = sgs_pkg::ANGLE_MAX;
        end
    end

    assign w_x = {11'd0, w_f} * {7'd0, sgs_pkg::PULSE_SPAN};

    // angle*2197/180 as (x/4)/45
    assign w_prod  = {18'd0, r_s1_x[18:2]} * {17'd0, RECIP_45};
    assign w_pulse = sgs_pkg::PULSE_MIN + w_prod[34:23];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_wr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_ch   <= i_req.ch;
            r_s1_f    <= w_f;
            r_s1_x    <= w_x;
            r_s1_mode <= i_req.mode_now;
            r_s1_last <= i_req.last;
        end
        if (w_s1_move) begin
            r_out_ch    <= r_s1_ch;
            r_out_f     <= r_s1_f;
            r_out_pulse <= w_pulse;
            r_out_mode  <= r_s1_mode;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_wr.valid         = r_out_valid;
    assign o_wr.servo_channel = r_out_ch;
    assign o_wr.servo_angle   = r_out_f;
    assign o_wr.pulse_us      = r_out_pulse;
    assign o_wr.mode_now      = r_out_mode;
    assign o_wr.last          = r_out_last;

endmodule

### hw/rtl/sgs_seq.sv
// command sequencer: gait, ramp and watchdog state, issues servo writes one at a time
module sgs_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgs_pkg::t_cfg     i_cfg,
    sgs_cmd_if.sink           i_cmd,
    output logic              o_req_valid,
    input  logic              i_req_ready,
    output sgs_pkg::t_wr_req  o_req
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_PLAN   = 2'd2;
    localparam logic [1:0] ST_ISSUE  = 2'd3;

    localparam logic [1:0] JOB_NONE   = 2'd0;
    localparam logic [1:0] JOB_PHASE  = 2'd1;
    localparam logic [1:0] JOB_RAMP   = 2'd2;
    localparam logic [1:0] JOB_SINGLE = 2'd3;

    // ceil(d / 10) = ((d + 9) * RECIP_10) >> 14 for d + 9 up to 1032
    localparam logic [10:0] RECIP_10  = 11'd1639;
    localparam logic [10:0] ROUND_ADD = 11'd9;
    localparam logic [10:0] DUR_MIN   = 11'd10;
    localparam logic [10:0] DUR_MAX   = 11'd1020;
    localparam logic [9:0]  ELAPSED_LIMIT = 10'd1020;

    localparam int N = sgs_pkg::SERVO_COUNT;

    logic [1:0]  r_state, n_state;
    logic [1:0]  r_job, n_job;
    logic [1:0]  r_kind;
    logic [2:0]  r_cmd_mode;
    logic [2:0]  r_cmd_ch;
    logic [7:0]  r_cmd_ang;
    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_phase, n_phase;
    logic [9:0]  r_elapsed, n_elapsed;
    logic [7:0]  r_angle [N];
    logic [7:0]  n_angle [N];
    logic        r_ramp_active, n_ramp_active;
    logic [7:0]  r_ramp_target, n_ramp_target;
    logic [3:0]  r_ramp_timer, n_ramp_timer;
    logic [11:0] r_age, n_age;
    logic [N-1:0] r_mask, n_mask;
    logic [1:0]  r_k, n_k;
    logic [10:0] r_dur;

    logic        w_accept;
    logic [9:0]  w_d;
    logic [10:0] w_d9;
    logic [21:0] w_dprod;
    logic [10:0] w_dur_raw;
    logic [10:0] w_dur;
    logic [10:0] w_el;
    logic [3:0]  w_timer;
    logic [2:0]  w_mode_m1;
    logic [2:0]  w_ch;
    logic [7:0]  w_a;
    logic [7:0]  w_step;
    logic [N-1:0] w_sel;
    sgs_pkg::t_gait_entry w_entry;

    assign w_accept    = (r_state == ST_IDLE) && i_cmd.valid;
    assign i_cmd.ready = (r_state == ST_IDLE);

    // phase length, registered from settled phase and long phase setting
    always_comb begin
        w_d       = r_phase[0] ? {1'b0, i_cfg.long_phase_ms[9:1]} : i_cfg.long_phase_ms;
        w_d9      = {1'b0, w_d} + ROUND_ADD;
        w_dprod   = {11'd0, w_d9} * {11'd0, RECIP_10};
        w_dur_raw = {4'd0, w_dprod[20:14]} * 11'd10;
        if (w_dur_raw < DUR_MIN) begin
            w_dur = DUR_MIN;
        end else if (w_dur_raw > DUR_MAX) begin
            w_dur = DUR_MAX;
        end else begin
            w_dur = w_dur_raw;
        end
    end

    // lowest pending ramp channel
    always_comb begin
        w_ch = 3'd0;
        for (int c = N - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                w_ch = 3'(c);
            end
        end
        w_sel = N'(1) << w_ch;
        w_a   = r_angle[w_ch];
        if (w_a < r_ramp_target) begin
            w_step = (r_ramp_target - w_a > sgs_pkg::RAMP_STEP) ?
                     w_a + sgs_pkg::RAMP_STEP : r_ramp_target;
        end else begin
            w_step = (w_a - r_ramp_target > sgs_pkg::RAMP_STEP) ?
                     w_a - sgs_pkg::RAMP_STEP : r_ramp_target;
        end
    end

    assign w_mode_m1 = r_mode - 3'd1;
    assign w_entry   = sgs_pkg::GAIT_TABLE[{w_mode_m1[1:0], r_phase, r_k}];
    assign w_el      = {1'b0, r_elapsed} + 11'd1;
    assign w_timer   = r_ramp_timer + 4'd1;

    always_comb begin
        n_state       = r_state;
        n_job         = r_job;
        n_mode        = r_mode;
        n_phase       = r_phase;
        n_elapsed     = r_elapsed;
        n_angle       = r_angle;
        n_ramp_active = r_ramp_active;
        n_ramp_target = r_ramp_target;
        n_ramp_timer  = r_ramp_timer;
        n_age         = r_age;
        n_mask        = r_mask;
        n_k           = r_k;
        o_req_valid   = 1'b0;
        o_req         = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = ST_DECODE;
                end
            end

            ST_DECODE: begin
                n_job = JOB_NONE;
                n_k   = 2'd0;
                if (r_kind == sgs_pkg::KIND_TICK) begin
                    n_age = (r_age != sgs_pkg::AGE_MAX) ? r_age + 12'd1 : r_age;
                    if (r_mode != sgs_pkg::MODE_REST && n_age > i_cfg.watchdog_ms) begin
                        n_mode        = sgs_pkg::MODE_REST;
                        n_phase       = 2'd0;
                        n_elapsed     = 10'd0;
                        n_ramp_target = sgs_pkg::STAND_ANGLE;
                        n_ramp_active = 1'b1;
                        n_ramp_timer  = 4'd0;
                        n_job         = JOB_RAMP;
                    end else begin
                        if (r_mode != sgs_pkg::MODE_REST) begin
                            if (w_el >= r_dur) begin
                                n_phase   = r_phase + 2'd1;
                                n_elapsed = 10'd0;
                                n_job     = JOB_PHASE;
                            end else begin
                                n_elapsed = w_el[9:0];
                            end
                        end
                        // a ramp only runs while standing, so never with a phase change
                        if (r_ramp_active) begin
                            if (w_timer >= sgs_pkg::RAMP_PERIOD) begin
                                n_ramp_timer = 4'd0;
                                n_job        = JOB_RAMP;
                            end else begin
                                n_ramp_timer = w_timer;
                            end
                        end
                    end
                end else begin
                    n_age = 12'd0;
                    case (r_kind)
                        sgs_pkg::KIND_MODE: begin
                            if (r_cmd_mode <= sgs_pkg::MODE_MAX && r_cmd_mode != r_mode) begin
                                n_mode    = r_cmd_mode;
                                n_phase   = 2'd0;
                                n_elapsed = 10'd0;
                                if (r_cmd_mode != sgs_pkg::MODE_REST) begin
                                    n_ramp_active = 1'b0;
                                    n_ramp_timer  = 4'd0;
                                    n_job         = JOB_PHASE;
                                end
                            end
                        end
                        sgs_pkg::KIND_SET: begin
                            n_mode        = sgs_pkg::MODE_REST;
                            n_phase       = 2'd0;
                            n_elapsed     = 10'd0;
                            n_ramp_active = 1'b0;
                            n_ramp_timer  = 4'd0;
                            n_job         = JOB_SINGLE;
                        end
                        default: begin
                            n_mode        = sgs_pkg::MODE_REST;
                            n_phase       = 2'd0;
                            n_elapsed     = 10'd0;
                            n_ramp_target = r_cmd_ang;
                            n_ramp_active = 1'b1;
                            n_ramp_timer  = 4'd0;
                            n_job         = JOB_RAMP;
                        end
                    endcase
                end
                case (n_job)
                    JOB_NONE: n_state = ST_IDLE;
                    JOB_RAMP: n_state = ST_PLAN;
                    default:  n_state = ST_ISSUE;
                endcase
            end

            ST_PLAN: begin
                for (int c = 0; c < N; c++) begin
                    n_mask[c] = (r_angle[c] != r_ramp_target);
                end
                if (n_mask == '0) begin
                    n_ramp_active = 1'b0;
                    n_state       = ST_IDLE;
                end else begin
                    n_state = ST_ISSUE;
                end
            end

            ST_ISSUE: begin
                o_req_valid    = 1'b1;
                o_req.mode_now = r_mode;
                case (r_job)
                    JOB_PHASE: begin
                        o_req.ch   = w_entry.ch;
                        o_req.ang  = w_entry.ang;
                        o_req.last = (r_k == 2'd3);
                    end
                    JOB_RAMP: begin
                        o_req.ch   = w_ch;
                        o_req.ang  = w_step;
                        o_req.last = ((r_mask & ~w_sel) == '0);
                    end
                    default: begin
                        o_req.ch   = r_cmd_ch;
                        o_req.ang  = r_cmd_ang;
                        o_req.last = 1'b1;
                    end
                endcase
                if (i_req_ready) begin
                    n_angle[o_req.ch] = o_req.ang;
                    n_k               = r_k + 2'd1;
                    n_mask            = r_mask & ~w_sel;
                    if (o_req.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_job         <= JOB_NONE;
            r_mode        <= sgs_pkg::MODE_REST;
            r_phase       <= 2'd0;
            r_elapsed     <= 10'd0;
            r_ramp_active <= 1'b0;
            r_ramp_target <= sgs_pkg::STAND_ANGLE;
            r_ramp_timer  <= 4'd0;
            r_age         <= 12'd0;
            r_mask        <= '0;
            r_k           <= 2'd0;
            for (int c = 0; c < N; c++) begin
                r_angle[c] <= sgs_pkg::STAND_ANGLE;
            end
        end else begin
            r_state       <= n_state;
            r_job         <= n_job;
            r_mode        <= n_mode;
            r_phase       <= n_phase;
            r_elapsed     <= n_elapsed;
            r_ramp_active <= n_ramp_active;
            r_ramp_target <= n_ramp_target;
            r_ramp_timer  <= n_ramp_timer;
            r_age         <= n_age;
            r_mask        <= n_mask;
            r_k           <= n_k;
            r_angle       <= n_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dur <= w_dur;
        if (w_accept) begin
            r_kind     <= i_cmd.kind;
            r_cmd_mode <= i_cmd.mode;
            r_cmd_ch   <= i_cmd.channel;
            r_cmd_ang  <= i_cmd.angle;
        end
    end

    a_ramp_only_standing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ramp_active |-> r_mode == sgs_pkg::MODE_REST)
        else $error("ramp active while walking");

    a_elapsed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elapsed < ELAPSED_LIMIT)
        else $error("phase elapsed beyond longest phase");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_DECODE)
        else $error("accepted word not decoded");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req_valid && i_req_ready && o_req.last) |=> r_state == ST_IDLE)
        else $error("sequencer busy after final write");

endmodule

### hw/rtl/servo_gait_sequencer.sv
// top level of the eight-channel servo gait sequencer
// Each command word (1 ms tick, mode request, channel set, ramp all) is accepted only while
// the sequencer is idle. It decodes the word in a decode state, plans a ramp step in a
// planning state, then issues one servo write per cycle to the shared write unit while that
// unit is ready: four writes for a gait phase, one for a channel set, none for a plain tick and
// up to eight for a ramp step that moves all eight channels. The write unit computes the
// inverted, clamped angle and its pulse width in two stages (scaling product, then a
// reciprocal product for the divide by 180) and holds each result word in an output
// register, so the next command can be taken while the last writes drain. Output back
// pressure stalls the sequencer one write at a time. Configuration sits on an APB port
// at byte addresses 0, 4 and 8 and must only change while no results are pending.
module servo_gait_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sgs_cmd_if.sink     i_cmd,
    sgs_wr_if.source    o_wr,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sgs_pkg::t_cfg    w_cfg;
    sgs_pkg::t_wr_req w_req;
    logic             w_req_valid;
    logic             w_req_ready;

    assign pready = 1'b1;

    sgs_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    sgs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (i_cmd),
        .o_req_valid (w_req_valid),
        .i_req_ready (w_req_ready),
        .o_req       (w_req)
    );

    sgs_writer u_writer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req_valid (w_req_valid),
        .o_req_ready (w_req_ready),
        .i_req       (w_req),
        .o_wr        (o_wr)
    );

endmodule
